FILE: sv/skvt_pkg.sv
// skvt_pkg: shared types for the sorted key/value table.
// Entry layout, result codes and controller-to-datapath command/status bundles.
// No dependencies.
package skvt_pkg;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FOUND     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    RES_INSERTED = 2'd0,
    RES_FULL     = 2'd1,
    RES_LOOKUP   = 2'd2
  } res_t;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_LOOKUP = 1'b1;

  typedef struct packed {
    logic signed [31:0] key;
    logic [31:0]        value;
  } entry_t;

  typedef struct packed {
    logic latch;
    logic ins_rd;
    logic ins_shift;
    logic ins_place;
    logic srch_rd;
    logic srch_step;
    logic fin_rd;
    logic set_res;
    res_t res;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic in_lookup;
    logic full;
    logic j_zero;
    logic shift_needed;
    logic search_open;
    logic out_busy;
  } stat_t;

endpackage

FILE: sv/skvt_if.sv
// skvt_if: valid/ready channel interfaces for the sorted key/value table.
// Request channel and result channel. Uses no package.
interface skvt_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] key;
  logic [31:0]        value;
  modport source (output valid, kind, key, value, input ready);
  modport sink   (input valid, kind, key, value, output ready);
endinterface

interface skvt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] found_value;
  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface

FILE: sv/skvt_ctrl.sv
// skvt_ctrl: sequencer for insert (shift-in sort) and lookup (binary search).
// Depends on skvt_pkg for cmd_t, stat_t and res_t.
module skvt_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  skvt_pkg::stat_t stat,
  output skvt_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_INS_RD   = 7'b0000010,
    S_INS_CMP  = 7'b0000100,
    S_SRCH_RD  = 7'b0001000,
    S_SRCH_CMP = 7'b0010000,
    S_FIN_CMP  = 7'b0100000,
    S_DONE     = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    cmd.res   = skvt_pkg::RES_INSERTED;
    in_ready  = 1'b0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          if (stat.in_lookup) begin
            state_nxt = S_SRCH_RD;
          end else if (stat.full) begin
            cmd.set_res = 1'b1;
            cmd.res     = skvt_pkg::RES_FULL;
            state_nxt   = S_DONE;
          end else begin
            state_nxt = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        if (stat.j_zero) begin
          cmd.ins_place = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res       = skvt_pkg::RES_INSERTED;
          state_nxt     = S_DONE;
        end else begin
          cmd.ins_rd = 1'b1;
          state_nxt  = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (stat.shift_needed) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_INS_RD;
        end else begin
          cmd.ins_place = 1'b1;
          cmd.set_res   = 1'b1;
          cmd.res       = skvt_pkg::RES_INSERTED;
          state_nxt     = S_DONE;
        end
      end
      S_SRCH_RD: begin
        if (stat.search_open) begin
          cmd.srch_rd = 1'b1;
          state_nxt   = S_SRCH_CMP;
        end else begin
          cmd.fin_rd = 1'b1;
          state_nxt  = S_FIN_CMP;
        end
      end
      S_SRCH_CMP: begin
        cmd.srch_step = 1'b1;
        state_nxt     = S_SRCH_RD;
      end
      S_FIN_CMP: begin
        cmd.set_res = 1'b1;
        cmd.res     = skvt_pkg::RES_LOOKUP;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/skvt_dp.sv
// skvt_dp: entry memory, search/shift indices, result and output registers.
// Depends on skvt_pkg for entry_t, cmd_t, stat_t, res_t and status_t.
module skvt_dp #(
  parameter int CAPACITY = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  skvt_pkg::cmd_t     cmd,
  output skvt_pkg::stat_t    stat,
  input  logic               in_kind,
  input  logic signed [31:0] in_key,
  input  logic [31:0]        in_value,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [31:0]        out_found_value
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  skvt_pkg::entry_t mem [CAPACITY];
  skvt_pkg::entry_t rd_q_r;

  logic signed [31:0] key_r;
  logic [31:0]        val_r;
  logic [CNT_W-1:0]   count_r;
  logic [CNT_W-1:0]   j_r;
  logic [CNT_W-1:0]   lo_r;
  logic [CNT_W-1:0]   hi_r;
  logic [CNT_W-1:0]   mid_r;
  logic [CNT_W:0]     mid_sum;
  logic [CNT_W-1:0]   mid_w;
  logic [CNT_W-1:0]   jm1;
  logic               lo_in_range;

  skvt_pkg::status_t  res_status_r;
  logic [31:0]        res_value_r;
  logic               out_valid_r;
  skvt_pkg::status_t  out_status_r;
  logic [31:0]        out_value_r;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  skvt_pkg::entry_t   wdata;
  logic               re;
  logic [IDX_W-1:0]   raddr;

  assign mid_sum     = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid_w       = mid_sum[CNT_W:1];
  assign jm1         = j_r - CNT_W'(1);
  assign lo_in_range = lo_r < count_r;

  assign we    = cmd.ins_shift | cmd.ins_place;
  assign waddr = j_r[IDX_W-1:0];
  assign wdata = cmd.ins_shift ? rd_q_r : {key_r, val_r};
  assign re    = cmd.ins_rd | cmd.srch_rd | cmd.fin_rd;

  always_comb begin
    raddr = '0;
    if (cmd.ins_rd) begin
      raddr = jm1[IDX_W-1:0];
    end else if (cmd.srch_rd) begin
      raddr = mid_w[IDX_W-1:0];
    end else if (lo_in_range) begin
      raddr = lo_r[IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rd_q_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.ins_place) begin
      count_r <= count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      key_r <= in_key;
      val_r <= in_value;
      j_r   <= count_r;
      lo_r  <= '0;
      hi_r  <= count_r;
    end else begin
      if (cmd.ins_shift) begin
        j_r <= jm1;
      end
      if (cmd.srch_rd) begin
        mid_r <= mid_w;
      end
      if (cmd.srch_step) begin
        if ($signed(rd_q_r.key) < key_r) begin
          lo_r <= mid_r + CNT_W'(1);
        end else begin
          hi_r <= mid_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      case (cmd.res)
        skvt_pkg::RES_INSERTED: begin
          res_status_r <= skvt_pkg::ST_INSERTED;
          res_value_r  <= '0;
        end
        skvt_pkg::RES_FULL: begin
          res_status_r <= skvt_pkg::ST_FULL;
          res_value_r  <= '0;
        end
        skvt_pkg::RES_LOOKUP: begin
          if (lo_in_range && ($signed(rd_q_r.key) == key_r)) begin
            res_status_r <= skvt_pkg::ST_FOUND;
            res_value_r  <= rd_q_r.value;
          end else begin
            res_status_r <= skvt_pkg::ST_NOT_FOUND;
            res_value_r  <= '0;
          end
        end
        default: begin
          res_status_r <= skvt_pkg::ST_NOT_FOUND;
          res_value_r  <= '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  assign stat.in_lookup    = (in_kind == skvt_pkg::KIND_LOOKUP);
  assign stat.full         = (count_r == CNT_W'(CAPACITY));
  assign stat.j_zero       = (j_r == '0);
  assign stat.shift_needed = ($signed(rd_q_r.key) > key_r);
  assign stat.search_open  = (lo_r < hi_r);
  assign stat.out_busy     = out_valid_r & ~out_ready;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;

endmodule

FILE: sv/sorted_key_value_table.sv
// sorted_key_value_table: fixed-capacity key to value table kept in key order.
// Depends on skvt_pkg, skvt_if, skvt_ctrl and skvt_dp.
//
//   channel | dir | payload                      | beat when
//   in_ch   | in  | kind, key, value             | valid && ready
//   out_ch  | out | status, found_value          | valid && ready
//
// One item at a time; one memory read per step with registered data.
// Insert: each stored entry with a key greater than the new one is read and shifted up,
// then the new entry is placed above any equal keys; a full table is answered at once.
// Lookup: a binary search narrows lo/hi, then the entry at lo is read and compared.
// A finished result waits in the output register; the next beat is taken meanwhile.
// Reset is synchronous and empties the table at once; no clearing pass.
module sorted_key_value_table #(
  parameter int CAPACITY = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  skvt_in_if.sink    in_ch,
  skvt_out_if.source out_ch
);

  skvt_pkg::cmd_t  cmd;
  skvt_pkg::stat_t stat;

  skvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  skvt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_ch.kind),
    .in_key          (in_ch.key),
    .in_value        (in_ch.value),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_status      (out_ch.status),
    .out_found_value (out_ch.found_value)
  );

endmodule

FILE: sv/skvt_checker.sv
// skvt_checker: port-level checks for the sorted key/value table, plus its bind.
// Depends on skvt_pkg for status codes; attaches to sorted_key_value_table.
module skvt_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [31:0] out_found_value
);

  logic [1:0] pend_r;
  logic       in_beat;
  logic       out_beat;

  assign in_beat  = in_valid & in_ready;
  assign out_beat = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + {1'b0, in_beat} - {1'b0, out_beat};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_found_value))
    else $error("result changed while stalled");

  a_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != skvt_pkg::ST_FOUND) |-> out_found_value == '0)
    else $error("non-zero value without a match");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result beat with no request outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two requests outstanding");

  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> !in_ready)
    else $error("request taken while previous one still in work");

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_status      (out_ch.status),
  .out_found_value (out_ch.found_value)
);

FILE: sim/tb_sorted_key_value_table.sv
`timescale 1ns / 100ps
// tb_sorted_key_value_table: self-checking bench for the sorted key/value table.
// Sends insert and lookup beats in random bursts against a stalling receiver and checks each
// result against a directed row or a table model here. Needs skvt_pkg, skvt_if and the RTL.
module tb_sorted_key_value_table;

  localparam int CAPACITY     = 64;
  localparam int N_RANDOM     = 1230;
  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 150;

  typedef struct {
    skvt_pkg::status_t status;
    logic [31:0]       value;
  } result_t;

  typedef struct {
    logic               kind;
    logic signed [31:0] key;
    logic [31:0]        value;
    bit                 typed;
    skvt_pkg::status_t  status;
    logic [31:0]        found;
  } stim_row_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  skvt_in_if  in_ch ();
  skvt_out_if out_ch ();

  sorted_key_value_table #(.CAPACITY(CAPACITY)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  logic signed [31:0] table_keys [CAPACITY];
  logic [31:0]        table_vals [CAPACITY];
  int                 table_fill = 0;
  result_t            pending_results [$];
  stim_row_t          directed_rows [$];
  result_t            oldest;
  int                 mismatch_count = 0;
  int                 idle_cycles = 0;
  int                 burst_left = 0;
  int                 n_inserted = 0;
  int                 n_found = 0;
  int                 n_missed = 0;
  int                 n_full = 0;
  bit                 hold_request = 1'b0;

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    $display("mismatch @%0t: %s", $time, what);
  endtask

  // entries kept in arrival order; the lowest index with the key is the earliest insert
  task automatic table_apply(input logic kind, input logic signed [31:0] key,
                             input logic [31:0] value, output result_t res);
    res.status = skvt_pkg::ST_NOT_FOUND;
    res.value  = '0;
    if (kind == skvt_pkg::KIND_INSERT) begin
      if (table_fill >= CAPACITY) begin
        res.status = skvt_pkg::ST_FULL;
      end else begin
        table_keys[table_fill] = key;
        table_vals[table_fill] = value;
        table_fill++;
        res.status = skvt_pkg::ST_INSERTED;
      end
    end else begin
      for (int i = table_fill - 1; i >= 0; i--) begin
        if (table_keys[i] == key) begin
          res.status = skvt_pkg::ST_FOUND;
          res.value  = table_vals[i];
        end
      end
    end
  endtask

  task automatic add_row(input logic kind, input logic signed [31:0] key,
                         input logic [31:0] value, input bit typed,
                         input skvt_pkg::status_t status, input logic [31:0] found);
    stim_row_t row;
    row.kind   = kind;
    row.key    = key;
    row.value  = value;
    row.typed  = typed;
    row.status = status;
    row.found  = found;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  function automatic logic signed [31:0] pool_key();
    case ($urandom_range(0, 9))
      0:       return 32'sd0;
      1:       return 32'sd1;
      2:       return -32'sd1;
      3:       return 32'sh7FFF_FFFF;
      4:       return 32'sh8000_0000;
      5:       return 32'sh8000_0001;
      6:       return 32'sh7FFF_FFFE;
      default: return $signed($urandom_range(0, 15)) - 32'sd8;
    endcase
  endfunction

  // called at a falling edge; returns at the falling edge after the beat
  task automatic send_beat(input logic kind, input logic signed [31:0] key,
                           input logic [31:0] value, input bit typed,
                           input result_t typed_res);
    result_t res;
    int      gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.kind  <= kind;
    in_ch.key   <= key;
    in_ch.value <= value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    table_apply(kind, key, value, res);
    if (typed) pending_results.insert(pending_results.size(), typed_res);
    else pending_results.insert(pending_results.size(), res);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        flag_mismatch($sformatf("result beat with none pending, status %0d", out_ch.status));
      end else begin
        oldest = pending_results.pop_front();
        if (out_ch.status !== oldest.status)
          flag_mismatch($sformatf("status %0d, want %0d", out_ch.status, oldest.status));
        if (out_ch.found_value !== oldest.value)
          flag_mismatch($sformatf("found_value %h, want %h", out_ch.found_value, oldest.value));
      end
      case (out_ch.status)
        skvt_pkg::ST_INSERTED:  n_inserted++;
        skvt_pkg::ST_FOUND:     n_found++;
        skvt_pkg::ST_NOT_FOUND: n_missed++;
        default:                n_full++;
      endcase
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_sorted_key_value_table failed");
      $finish;
    end
  end

  initial begin : receiver
    int run_left;
    int mode;
    int hold_left;
    run_left     = 0;
    mode         = 0;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        if (run_left == 0) begin
          mode     = $urandom_range(0, 2);
          run_left = $urandom_range(10, 80);
        end
        run_left--;
        case (mode)
          0:       out_ch.ready <= 1'b1;
          1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
          default: out_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : main
    result_t            typed_res;
    stim_row_t          row;
    logic               kind;
    logic signed [31:0] key;
    logic [31:0]        value;
    bit                 do_insert;
    int                 pick;
    in_ch.valid = 1'b0;
    in_ch.kind  = skvt_pkg::KIND_INSERT;
    in_ch.key   = '0;
    in_ch.value = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    add_row(skvt_pkg::KIND_LOOKUP, 32'sd0,         32'hFFFF_FFFF, 1,
            skvt_pkg::ST_NOT_FOUND, 32'h0);
    add_row(skvt_pkg::KIND_INSERT, 32'sh7FFF_FFFF, 32'hFFFF_FFFF, 1,
            skvt_pkg::ST_INSERTED,  32'h0);
    add_row(skvt_pkg::KIND_INSERT, 32'sh8000_0000, 32'h0000_0000, 1,
            skvt_pkg::ST_INSERTED,  32'h0);
    add_row(skvt_pkg::KIND_INSERT, 32'sd0,         32'h1234_5678, 1,
            skvt_pkg::ST_INSERTED,  32'h0);
    add_row(skvt_pkg::KIND_INSERT, -32'sd1,        32'hA5A5_A5A5, 1,
            skvt_pkg::ST_INSERTED,  32'h0);
    add_row(skvt_pkg::KIND_LOOKUP, 32'sh7FFF_FFFF, 32'h0,         1,
            skvt_pkg::ST_FOUND,     32'hFFFF_FFFF);
    add_row(skvt_pkg::KIND_LOOKUP, 32'sh8000_0000, 32'h0,         1,
            skvt_pkg::ST_FOUND,     32'h0);
    add_row(skvt_pkg::KIND_LOOKUP, -32'sd1,        32'h0,         1,
            skvt_pkg::ST_FOUND,     32'hA5A5_A5A5);
    add_row(skvt_pkg::KIND_LOOKUP, 32'sd1,         32'h0,         1,
            skvt_pkg::ST_NOT_FOUND, 32'h0);
    add_row(skvt_pkg::KIND_LOOKUP, 32'sh7FFF_FFFE, 32'h0,         1,
            skvt_pkg::ST_NOT_FOUND, 32'h0);
    add_row(skvt_pkg::KIND_LOOKUP, 32'sh8000_0001, 32'h0,         1,
            skvt_pkg::ST_NOT_FOUND, 32'h0);
    // duplicate key inserted after a sort; the earlier entry must still answer
    add_row(skvt_pkg::KIND_INSERT, 32'sd0,         32'hDEAD_BEEF, 1,
            skvt_pkg::ST_INSERTED,  32'h0);
    add_row(skvt_pkg::KIND_LOOKUP, 32'sd0,         32'h0,         1,
            skvt_pkg::ST_FOUND,     32'h1234_5678);
    add_row(skvt_pkg::KIND_INSERT, 32'sd5,         32'h5555_AAAA, 0,
            skvt_pkg::ST_INSERTED,  32'h0);
    add_row(skvt_pkg::KIND_LOOKUP, 32'sd5,         32'h0,         0,
            skvt_pkg::ST_INSERTED,  32'h0);
    add_row(skvt_pkg::KIND_INSERT, -32'sd5,        32'h0F0F_F0F0, 0,
            skvt_pkg::ST_INSERTED,  32'h0);
    add_row(skvt_pkg::KIND_INSERT, 32'sd5,         32'h3C3C_C3C3, 0,
            skvt_pkg::ST_INSERTED,  32'h0);
    add_row(skvt_pkg::KIND_LOOKUP, 32'sd5,         32'h0,         0,
            skvt_pkg::ST_INSERTED,  32'h0);
    add_row(skvt_pkg::KIND_LOOKUP, -32'sd5,        32'h0,         0,
            skvt_pkg::ST_INSERTED,  32'h0);
    add_row(skvt_pkg::KIND_LOOKUP, 32'sd4,         32'h0,         0,
            skvt_pkg::ST_INSERTED,  32'h0);

    for (int r = 0; r < directed_rows.size(); r++) begin
      row              = directed_rows[r];
      typed_res.status = row.status;
      typed_res.value  = row.found;
      send_beat(row.kind, row.key, row.value, row.typed, typed_res);
    end

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 300) hold_request = 1'b1;
      if (n == 650) begin
        in_ch.valid <= 1'b0;
        do @(negedge clk); while (pending_results.size() != 0);
      end
      do_insert = ($urandom_range(0, 11) == 0) || (n >= 1000 && table_fill < CAPACITY);
      value     = $urandom;
      pick      = $urandom_range(0, 19);
      if (do_insert) begin
        kind = skvt_pkg::KIND_INSERT;
        key  = pick[0] ? pool_key() : $urandom;
      end else begin
        kind = skvt_pkg::KIND_LOOKUP;
        if (table_fill > 0 && pick < 12)
          key = table_keys[$urandom_range(0, table_fill - 1)];
        else if (table_fill > 0 && pick < 15)
          key = table_keys[$urandom_range(0, table_fill - 1)] +
                (pick[0] ? 32'sd1 : -32'sd1);
        else if (pick < 17)
          key = pool_key();
        else
          key = $urandom;
      end
      send_beat(kind, key, value, 1'b0, typed_res);
    end

    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered: %0d inserts stored, %0d rejected as full, %0d lookups hit, %0d missed",
             n_inserted, n_full, n_found, n_missed);
    $display("table ended with %0d of %0d entries; %0d mismatches",
             table_fill, CAPACITY, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb_sorted_key_value_table passed");
    end else begin
      $display("tb_sorted_key_value_table failed");
    end
    $finish;
  end

endmodule
